[hdl/scy_pkg.sv]
// shared types and constants for the scytale transposition core
package scy_pkg;

   localparam int MAX_LEN    = 64;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int DIAM_W     = LEN_W;
   localparam int CNT_W      = $clog2(LEN_W);
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIAM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_DIAMETER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE   = 2'd1;

   localparam logic [DIAM_W-1:0] DIAM_RESET = 7'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
      logic              truncated;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic              step;
      logic [LEN_W-1:0]  len;
      logic [DIAM_W-1:0] rows;
      logic              decode;
   } gen_cmd_type;

   typedef struct packed {
      logic              idle;
      logic              ready;
      logic              last;
      logic [ADDR_W-1:0] addr;
   } gen_stat_type;

endpackage

[hdl/scytale_transposition_core.sv]
// scytale transposition core: loads a message, then emits it transposed
// loading takes one byte transfer per cycle into the message ram, while the sequencer is idle
// after the final byte, a column divider runs, then one ram read per cycle unless the result is stalled
// each ram read is registered and is presented as the result with its last and truncated flags
// reset is synchronous: clears byte count, overflow flag, result valid, sequencer state, diameter to 2, encode mode
module scytale_transposition_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  scy_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output scy_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scy_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scy_pkg::CSR_DATA_W-1:0]     csr_data
);
   import scy_pkg::*;

   logic [LEN_W-1:0]  count_ff, count_in;
   logic              ov_ff, ov_in;
   logic              trunc_run_ff, trunc_run_in;
   logic [DIAM_W-1:0] diam_ff, diam_in;
   logic              mode_ff, mode_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_trunc_ff, rsp_trunc_in;

   logic              req_xfer;
   logic              csr_xfer;
   logic              store_ok;
   logic              wr_en;
   logic              issue;
   logic [BYTE_W-1:0] rd_data;
   gen_cmd_type       cmd;
   gen_stat_type      stat;

   assign req_ready = stat.idle;
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;
   assign store_ok  = count_ff < LEN_W'(MAX_LEN);
   assign wr_en     = req_xfer && store_ok;
   assign issue     = stat.ready && (!rsp_valid_ff || rsp_ready);

   assign cmd.start  = req_xfer && req_payload.last_byte;
   assign cmd.step   = issue;
   assign cmd.len    = store_ok ? count_ff + LEN_W'(1) : count_ff;
   assign cmd.rows   = diam_ff;
   assign cmd.decode = mode_ff;

   always_comb begin
      count_in     = count_ff;
      ov_in        = ov_ff;
      trunc_run_in = trunc_run_ff;
      diam_in      = diam_ff;
      mode_in      = mode_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      if (req_xfer) begin
         if (req_payload.last_byte) begin
            count_in     = '0;
            ov_in        = 1'b0;
            trunc_run_in = ov_ff || !store_ok;
         end else begin
            count_in = count_ff + LEN_W'(store_ok);
            ov_in    = ov_ff || !store_ok;
         end
      end

      if (csr_xfer) begin
         unique case (csr_index)
            CSR_RING_DIAMETER: diam_in = csr_data;
            CSR_DECODE_MODE:   mode_in = csr_data[0];
            default: begin
            end
         endcase
      end

      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = stat.last;
         rsp_trunc_in = trunc_run_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ov_ff        <= 1'b0;
         diam_ff      <= DIAM_RESET;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ov_ff        <= ov_in;
         diam_ff      <= diam_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trunc_run_ff <= trunc_run_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   scy_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_payload.data_byte),
      .rd_en   (issue),
      .rd_addr (stat.addr),
      .rd_data (rd_data)
   );

   scy_addr_gen u_gen (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = '{out_byte: rd_data, out_last: rsp_last_ff, truncated: rsp_trunc_ff};

`ifndef ASSERT_OFF
   a_no_read_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !issue)
      else $error("ram read while result stalled");
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_payload.last_byte) |=> (count_ff == '0 && !ov_ff))
      else $error("load state not cleared after final byte");
   a_gen_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (issue && stat.last) |=> stat.idle)
      else $error("sequencer still busy after final read");
`endif

endmodule

[hdl/scy_ram.sv]
// generic single write port ram with registered read
module scy_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/scy_addr_gen.sv]
// read address sequencer: column count divider and grid walk
module scy_addr_gen (
   input  logic                 clock,
   input  logic                 reset,
   input  scy_pkg::gen_cmd_type cmd,
   output scy_pkg::gen_stat_type stat
);
   import scy_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [DIAM_W-1:0] rows_ff, rows_in;
   logic              mode_ff, mode_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIAM_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0]  quot_ff, quot_in;
   logic [LEN_W-1:0]  item_ff, item_in;
   logic [DIAM_W-1:0] f_ff, f_in;
   logic [LEN_W-1:0]  c_ff, c_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;

   logic [DIAM_W:0]   trial;
   logic [DIAM_W:0]   diff;
   logic              ge;
   logic [DIAM_W:0]   f_inc;
   logic              wrap;
   logic [LEN_W-1:0]  row_len;
   logic [LEN_W:0]    k_sum;
   logic              is_last;

   always_comb begin
      trial   = {rem_ff, quot_ff[LEN_W-1]};
      diff    = trial - {1'b0, rows_ff};
      ge      = trial >= {1'b0, rows_ff};
      f_inc   = {1'b0, f_ff} + (DIAM_W+1)'(1);
      wrap    = f_inc == {1'b0, rows_ff};
      row_len = (f_ff <= rem_ff) ? quot_ff + LEN_W'(1) : quot_ff;
      k_sum   = {1'b0, pos_ff} + {1'b0, rows_ff};
      is_last = item_ff == len_ff - LEN_W'(1);

      state_in = state_ff;
      len_in   = len_ff;
      rows_in  = rows_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      item_in  = item_ff;
      f_in     = f_ff;
      c_in     = c_ff;
      pos_in   = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               len_in   = cmd.len;
               rows_in  = (cmd.rows == '0) ? DIAM_W'(1) : cmd.rows;
               mode_in  = cmd.decode;
               quot_in  = cmd.len - LEN_W'(1);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[DIAM_W-1:0] : trial[DIAM_W-1:0];
            quot_in = {quot_ff[LEN_W-2:0], ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(LEN_W - 1)) begin
               state_in = ST_RUN;
               item_in  = '0;
               f_in     = '0;
               c_in     = '0;
               pos_in   = '0;
            end
         end
         ST_RUN: begin
            if (cmd.step) begin
               item_in = item_ff + LEN_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
               if (mode_ff) begin
                  if (wrap) begin
                     f_in   = '0;
                     c_in   = c_ff + LEN_W'(1);
                     pos_in = c_ff + LEN_W'(1);
                  end else begin
                     f_in   = f_inc[DIAM_W-1:0];
                     pos_in = pos_ff + row_len;
                  end
               end else begin
                  if (k_sum < {1'b0, len_ff}) begin
                     pos_in = k_sum[LEN_W-1:0];
                  end else begin
                     f_in   = f_inc[DIAM_W-1:0];
                     pos_in = f_inc[LEN_W-1:0];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      rows_ff <= rows_in;
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      item_ff <= item_in;
      f_ff    <= f_in;
      c_ff    <= c_in;
      pos_ff  <= pos_in;
   end

   assign stat.idle  = state_ff == ST_IDLE;
   assign stat.ready = state_ff == ST_RUN;
   assign stat.last  = is_last;
   assign stat.addr  = pos_ff[ADDR_W-1:0];

`ifndef ASSERT_OFF
   a_div_to_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_W'(LEN_W - 1)) |=> state_ff == ST_RUN)
      else $error("divider did not hand over to the walk");
   a_addr_in_msg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> pos_ff < len_ff)
      else $error("read index beyond message length");
   a_step_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> state_ff == ST_RUN)
      else $error("step outside of walk");
`endif

endmodule

[dv/scytale_transposition_core_tb.sv]
// testbench for the scytale transposition core: directed table, random messages, scoreboard
`timescale 1ns / 1ps

module scytale_transposition_core_tb;
   import scy_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;
   localparam logic [BYTE_W-1:0]    SPACE_CHAR   = 8'h20;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASE_BYTES   = 110;

   typedef struct packed {
      bit                wr;
      logic [DIAM_W-1:0] diam;
      logic              dec;
      bit                spare;
      logic [3:0]        len;
      logic [63:0]       text;
      logic [63:0]       want;
      bit                typed;
   } vector_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [BYTE_W-1:0] msg_mem [MAX_LEN];
   int unsigned       msg_len = 0;
   logic              msg_over = 1'b0;
   logic [DIAM_W-1:0] diam_q = DIAM_RESET;
   logic              decode_q = 1'b0;
   rsp_type           cipher_queue [$];
   bit                want_typed = 1'b0;
   logic [63:0]       want_bytes = '0;

   int err_count = 0;
   int stall_cycles = 0;
   int results_seen = 0;
   int runs_done = 0;
   int decode_runs = 0;
   int overflow_runs = 0;
   int bytes_sent = 0;
   int send_idle = 0;
   int recv_idle = 0;

   vector_row_type directed_tab [6];

   scytale_transposition_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic vector_row_type vector_row(bit wr, logic [DIAM_W-1:0] diam, logic dec,
                                                 bit spare, logic [3:0] len, logic [63:0] text,
                                                 logic [63:0] want, bit typed);
      vector_row_type r;
      r.wr = wr;
      r.diam = diam;
      r.dec = dec;
      r.spare = spare;
      r.len = len;
      r.text = text;
      r.want = want;
      r.typed = typed;
      return r;
   endfunction

   function automatic void flag_error(string what);
      err_count++;
      if (err_count <= 10) $display("ERROR: %s", what);
   endfunction

   // store one byte; on the final byte, lay the message on the scytale and queue the run
   task automatic load_and_transpose(req_type item);
      logic [BYTE_W-1:0] grid_out [MAX_LEN];
      int unsigned nrows, ncols, pos, k;
      rsp_type e;
      if (msg_len < MAX_LEN) begin
         msg_mem[msg_len] = item.data_byte;
         msg_len++;
      end else begin
         msg_over = 1'b1;
      end
      if (item.last_byte) begin
         nrows = (diam_q == 0) ? 1 : diam_q;
         ncols = (msg_len + nrows - 1) / nrows;
         pos = 0;
         for (int unsigned f = 0; f < nrows && f < msg_len; f++) begin
            for (int unsigned c = 0; c < ncols; c++) begin
               k = c * nrows + f;
               if (k < msg_len) begin
                  if (decode_q) grid_out[k] = msg_mem[pos];
                  else grid_out[pos] = msg_mem[k];
                  pos++;
               end
            end
         end
         for (int unsigned i = 0; i < msg_len; i++) begin
            e.out_byte = want_typed ? want_bytes[8*(msg_len-1-i) +: 8] : grid_out[i];
            e.out_last = (i + 1 == msg_len);
            e.truncated = msg_over;
            cipher_queue.push_back(e);
         end
         runs_done++;
         if (decode_q) decode_runs++;
         if (msg_over) overflow_runs++;
         msg_len = 0;
         msg_over = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         diam_q = DIAM_RESET;
         decode_q = 1'b0;
         msg_len = 0;
         msg_over = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RING_DIAMETER) diam_q = csr_data;
            else if (csr_index == CSR_DECODE_MODE) decode_q = csr_data[0];
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (cipher_queue.size() == 0) begin
               flag_error($sformatf("unexpected result byte %h last %b trunc %b",
                                    rsp_payload.out_byte, rsp_payload.out_last,
                                    rsp_payload.truncated));
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.out_last !== want.out_last ||
                   rsp_payload.truncated !== want.truncated) begin
                  flag_error($sformatf("result %0d: expected byte %h last %b trunc %b, got %h %b %b",
                                       results_seen, want.out_byte, want.out_last,
                                       want.truncated, rsp_payload.out_byte,
                                       rsp_payload.out_last, rsp_payload.truncated));
               end
            end
         end
         if (req_valid && req_ready) load_and_transpose(req_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // entered and left at a falling edge; valid stays high for a following byte
   task automatic send_byte(req_type item);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_csr(logic [DIAM_W-1:0] diam, logic dec, bit spare);
      logic [CSR_DATA_W-2:0] pad;
      pad = (CSR_DATA_W-1)'($urandom_range(63));
      put_csr(CSR_RING_DIAMETER, diam);
      put_csr(CSR_DECODE_MODE, {pad, dec});
      if (spare) begin
         put_csr(CSR_UNUSED_2, ~diam);
         put_csr(CSR_UNUSED_3, CSR_DATA_W'($urandom_range(127)));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (cipher_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_message(int unsigned n);
      req_type item;
      for (int unsigned i = 0; i < n; i++) begin
         item.data_byte = ($urandom_range(9) == 0) ? SPACE_CHAR
                                                   : BYTE_W'($urandom_range(255));
         item.last_byte = (i + 1 == n);
         send_byte(item);
      end
   endtask

   function automatic logic [DIAM_W-1:0] pick_diameter();
      unique case ($urandom_range(9))
         0: return 7'd0;
         1: return 7'd127;
         2: return 7'd64;
         3: return DIAM_W'($urandom_range(17, 126));
         default: return DIAM_W'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic int unsigned pick_length();
      unique case ($urandom_range(19))
         0, 1: return $urandom_range(65, 72);
         2: return MAX_LEN;
         3, 4, 5: return $urandom_range(13, 63);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   initial begin
      req_type item;
      int unsigned n, phase_bytes;

      directed_tab[0] = vector_row(0, 7'd2,   0, 0, 5, "ABCDE",   "ACEBD",   1);
      directed_tab[1] = vector_row(1, 7'd0,   0, 0, 3, 24'h00FF80, 24'h00FF80, 1);
      directed_tab[2] = vector_row(1, 7'd127, 0, 0, 3, "a b",     "a b",     1);
      directed_tab[3] = vector_row(1, 7'd2,   1, 0, 5, "ACEBD",   "ABCDE",   1);
      directed_tab[4] = vector_row(1, 7'd3,   0, 1, 7, "SCYTALE", "STECAYL", 1);
      directed_tab[5] = vector_row(1, 7'd1,   1, 0, 2, 16'h7FA5,  '0,        0);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_idle = 33;
      recv_idle = 83;
      foreach (directed_tab[i]) begin
         settle();
         if (directed_tab[i].wr)
            program_csr(directed_tab[i].diam, directed_tab[i].dec, directed_tab[i].spare);
         want_typed = directed_tab[i].typed;
         want_bytes = directed_tab[i].want;
         for (int j = 0; j < directed_tab[i].len; j++) begin
            item.data_byte = directed_tab[i].text[8*(directed_tab[i].len-1-j) +: 8];
            item.last_byte = (j == directed_tab[i].len - 1);
            send_byte(item);
         end
         req_valid <= 1'b0;
         want_typed = 1'b0;
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 33 : (ph == 1) ? 83 : 0;
         recv_idle = (ph == 0) ? 83 : (ph == 1) ? 33 : 0;
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            settle();
            program_csr(pick_diameter(), 1'($urandom_range(1)), $urandom_range(7) == 0);
            repeat ($urandom_range(1, 4)) begin
               n = (phase_bytes == 0) ? $urandom_range(65, 72) : pick_length();
               send_message(n);
               phase_bytes += n;
            end
            req_valid <= 1'b0;
         end
      end

      settle();
      if (cipher_queue.size() != 0)
         flag_error($sformatf("%0d expected results never arrived", cipher_queue.size()));

      $display("covered %0d messages (%0d bytes, %0d decode, %0d with dropped bytes)",
               runs_done, bytes_sent, decode_runs, overflow_runs);
      $display("%0d results compared across three idle/stall mixes", results_seen);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
